// ===== rtl/core/tsa_pkg.sv =====
// package with shared types and constants of the tunnel spi allocator
`timescale 1ns / 1ps
package tsa_pkg;
   localparam int ENTRIES_DEF  = 64;
   localparam int REF_BITS_DEF = 16;
   localparam int SPI_W        = 32;
   localparam int ADDR_W       = 64;

   localparam logic [1:0] OP_LOOKUP  = 2'd0;
   localparam logic [1:0] OP_ACQUIRE = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   localparam logic [2:0] ST_FOUND     = 3'd0;
   localparam logic [2:0] ST_ALLOC     = 3'd1;
   localparam logic [2:0] ST_NOTFOUND  = 3'd2;
   localparam logic [2:0] ST_EXHAUSTED = 3'd3;
   localparam logic [2:0] ST_RELEASED  = 3'd4;
   localparam logic [2:0] ST_REMOVED   = 3'd5;

   localparam logic REG_SPI_MIN = 1'b0;
   localparam logic REG_SPI_MAX = 1'b1;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_LOOK,
      FSM_SEARCH,
      FSM_RESP
   } fsm_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_INC,
      CMD_DEC,
      CMD_ALLOC
   } cmd_type;

   // broadcast to every cell
   typedef struct packed {
      cmd_type            cmd;
      logic [ADDR_W-1:0]  key_hi;
      logic [ADDR_W-1:0]  key_lo;
      logic [SPI_W-1:0]   cand;
   } ctrl_type;

   // accumulated from cell to cell
   typedef struct packed {
      logic               hit;
      logic [SPI_W-1:0]   spi;
      logic               last_ref;
      logic               used;
      logic               free;
   } link_type;
endpackage

// ===== rtl/core/tsa_cell.sv =====
// one table slot: address, spi and reference count, chained to its neighbor
`timescale 1ns / 1ps
module tsa_cell
   import tsa_pkg::*;
#(
   parameter int REF_BITS = REF_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  ctrl_type ctrl,
   input  link_type link_in,
   output link_type link_out
);
   logic                valid_ff, valid_in;
   logic [ADDR_W-1:0]   hi_ff, hi_in, lo_ff, lo_in;
   logic [SPI_W-1:0]    spi_ff, spi_in;
   logic [REF_BITS-1:0] refs_ff, refs_in;
   logic                hit, used, sel;

   assign hit  = valid_ff && hi_ff == ctrl.key_hi && lo_ff == ctrl.key_lo;
   assign used = valid_ff && spi_ff == ctrl.cand;
   // lowest free slot: no free cell before this one
   assign sel  = !valid_ff && !link_in.free;

   assign link_out.hit      = link_in.hit | hit;
   assign link_out.spi      = link_in.spi | (hit ? spi_ff : '0);
   assign link_out.last_ref = link_in.last_ref | (hit && refs_ff <= REF_BITS'(1));
   assign link_out.used     = link_in.used | used;
   assign link_out.free     = link_in.free | !valid_ff;

   always_comb begin
      valid_in = valid_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      spi_in   = spi_ff;
      refs_in  = refs_ff;
      case (ctrl.cmd)
         CMD_INC: begin
            if (hit && refs_ff != {REF_BITS{1'b1}}) refs_in = refs_ff + REF_BITS'(1);
         end
         CMD_DEC: begin
            if (hit) begin
               if (refs_ff <= REF_BITS'(1)) begin
                  valid_in = 1'b0;
                  refs_in  = '0;
               end else begin
                  refs_in = refs_ff - REF_BITS'(1);
               end
            end
         end
         CMD_ALLOC: begin
            if (sel) begin
               valid_in = 1'b1;
               hi_in    = ctrl.key_hi;
               lo_in    = ctrl.key_lo;
               spi_in   = ctrl.cand;
               refs_in  = REF_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      spi_ff  <= spi_in;
      refs_ff <= refs_in;
   end
endmodule

// ===== rtl/core/tunnel_spi_allocator.sv =====
// top level of the tunnel spi allocator: sequencer and row of table cells
`timescale 1ns / 1ps
// Binds 128-bit IPv6 source addresses to 32-bit SPIs in a row of ENTRIES
// cells, one slot per cell, all compared at once. One request is in work at
// a time. Lookup, release and an acquire that needs no new SPI go from the
// LOOK state, where the table is searched, straight to RESP with their result.
// An acquire that allocates passes the SEARCH state first, which tries
// candidate SPIs in turn (at most ENTRIES+1), each checked against all cells
// at once. The result waits in an output register until taken, and no
// new request is accepted meanwhile.
module tunnel_spi_allocator
   import tsa_pkg::*;
#(
   parameter int ENTRIES  = ENTRIES_DEF,
   parameter int REF_BITS = REF_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[1:0], addr_hi[65:2], addr_lo[129:66], zero pad
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // spi[31:0], status[34:32], zero pad
   output logic [39:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [31:0]  csr_data
);
   localparam int TW = $clog2(ENTRIES + 2);

   fsm_type            state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [ADDR_W-1:0]  hi_ff, hi_in, lo_ff, lo_in;
   logic [SPI_W-1:0]   min_ff, min_in, max_ff, max_in;
   logic [SPI_W-1:0]   next_ff, next_in, cand_ff, cand_in;
   logic [TW-1:0]      tries_ff, tries_in, cnt_ff, cnt_in;
   logic [SPI_W-1:0]   rspi_ff, rspi_in;
   logic [2:0]         rst_ff, rst_in;
   ctrl_type           ctrl;
   link_type           links [0:ENTRIES];
   link_type           res;
   logic [SPI_W-1:0]   lo_lim, adv;
   logic [SPI_W:0]     range_w;
   logic               done;

   assign links[0] = '0;
   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         tsa_cell #(.REF_BITS(REF_BITS)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .link_in  (links[g]),
            .link_out (links[g+1])
         );
      end
   endgenerate
   assign res = links[ENTRIES];

   assign req_tready = state_ff == FSM_IDLE;
   assign rsp_tvalid = state_ff == FSM_RESP;
   assign rsp_tdata  = {5'd0, rst_ff, rspi_ff};
   assign csr_ready  = 1'b1;

   assign lo_lim  = (min_ff == '0) ? SPI_W'(1) : min_ff;
   assign adv     = (next_ff < lo_lim || next_ff >= max_ff) ? lo_lim : next_ff + SPI_W'(1);
   assign range_w = {1'b0, max_ff} - {1'b0, lo_lim} + (SPI_W+1)'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: if (req_tvalid) state_in = FSM_LOOK;
         FSM_LOOK: begin
            if (op_ff == OP_ACQUIRE && !res.hit && res.free && lo_lim <= max_ff)
               state_in = FSM_SEARCH;
            else
               state_in = FSM_RESP;
         end
         FSM_SEARCH: if (done) state_in = FSM_RESP;
         FSM_RESP: if (rsp_tready) state_in = FSM_IDLE;
         default: state_in = FSM_IDLE;
      endcase
   end

   assign done = !res.used || (cnt_ff + TW'(1) >= tries_ff);

   // outputs and datapath
   always_comb begin
      op_in    = op_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      next_in  = next_ff;
      cand_in  = cand_ff;
      tries_in = tries_ff;
      cnt_in   = cnt_ff;
      rspi_in  = rspi_ff;
      rst_in   = rst_ff;
      ctrl.cmd    = CMD_NONE;
      ctrl.key_hi = hi_ff;
      ctrl.key_lo = lo_ff;
      ctrl.cand   = cand_ff;
      if (csr_valid) begin
         if (csr_index == REG_SPI_MIN) min_in = csr_data;
         if (csr_index == REG_SPI_MAX) max_in = csr_data;
      end
      case (state_ff)
         FSM_IDLE: begin
            if (req_tvalid) begin
               op_in = req_tdata[1:0];
               hi_in = req_tdata[65:2];
               lo_in = req_tdata[129:66];
            end
         end
         FSM_LOOK: begin
            rspi_in = '0;
            rst_in  = ST_NOTFOUND;
            case (op_ff)
               OP_LOOKUP: begin
                  if (res.hit) begin
                     rspi_in = res.spi;
                     rst_in  = ST_FOUND;
                  end
               end
               OP_ACQUIRE: begin
                  if (res.hit) begin
                     ctrl.cmd = CMD_INC;
                     rspi_in  = res.spi;
                     rst_in   = ST_FOUND;
                  end else begin
                     rst_in = ST_EXHAUSTED;
                     if (res.free) begin
                        next_in = adv;
                        cand_in = adv;
                        cnt_in  = '0;
                        tries_in = (range_w < (SPI_W+1)'(ENTRIES + 1)) ?
                                   TW'(range_w) : TW'(ENTRIES + 1);
                     end
                  end
               end
               OP_RELEASE: begin
                  if (res.hit) begin
                     ctrl.cmd = CMD_DEC;
                     rspi_in  = res.spi;
                     rst_in   = res.last_ref ? ST_REMOVED : ST_RELEASED;
                  end
               end
               default: begin
               end
            endcase
         end
         FSM_SEARCH: begin
            if (!res.used) begin
               ctrl.cmd = CMD_ALLOC;
               next_in  = cand_ff;
               rspi_in  = cand_ff;
               rst_in   = ST_ALLOC;
            end else begin
               cand_in = (cand_ff >= max_ff) ? lo_lim : cand_ff + SPI_W'(1);
               cnt_in  = cnt_ff + TW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         min_ff   <= SPI_W'(1);
         max_ff   <= '1;
         next_ff  <= '0;
      end else begin
         state_ff <= state_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         next_ff  <= next_in;
      end
      op_ff    <= op_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      cand_ff  <= cand_in;
      tries_ff <= tries_in;
      cnt_ff   <= cnt_in;
      rspi_ff  <= rspi_in;
      rst_ff   <= rst_in;
   end
endmodule
